### design/crcc_pkg.sv
// Shared types, codes and constants of the card reader channel control block.
package crcc_pkg;

    localparam logic [6:0] COLUMNS_PER_CARD = 7'd80;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int RESULT_W   = 35;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_ATTACH = 2'd2,
        FUNC_DETACH = 2'd3
    } func_t;

    localparam logic [1:0] RD_OK    = 2'd0;
    localparam logic [1:0] RD_ERROR = 2'd1;
    localparam logic [1:0] RD_EMPTY = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

    localparam logic [2:0] OPC_STATUS  = 3'd0;
    localparam logic [2:0] OPC_READ    = 3'd2;
    localparam logic [2:0] OPC_CONTROL = 3'd3;
    localparam logic [2:0] OPC_SENSE   = 3'd4;

    localparam logic [7:0] CMD_NOP     = 8'h03;
    localparam logic [7:0] CMD_SENSE   = 8'h04;
    localparam logic [7:0] OP_MASK     = 8'h27;
    localparam logic [7:0] OP_READ     = 8'h02;
    localparam logic [7:0] OP_SENSE    = 8'h04;
    localparam logic [7:0] STK_MASK    = 8'hC0;
    localparam logic [7:0] CTL_MASK    = 8'h30;
    localparam logic [7:0] CTL_FEED    = 8'h20;

    localparam logic [7:0] SENSE_REJECT = 8'h80;
    localparam logic [7:0] SENSE_INTERV = 8'h40;
    localparam logic [7:0] SENSE_DATCHK = 8'h08;

    localparam logic [4:0] ST_CE   = 5'h01;
    localparam logic [4:0] ST_DE   = 5'h02;
    localparam logic [4:0] ST_UC   = 5'h04;
    localparam logic [4:0] ST_UE   = 5'h08;
    localparam logic [4:0] ST_BUSY = 5'h10;

    localparam logic [1:0] WAIT_NONE   = 2'd0;
    localparam logic [1:0] WAIT_SHORT  = 2'd1;
    localparam logic [1:0] WAIT_COLUMN = 2'd2;
    localparam logic [1:0] WAIT_FEED   = 2'd3;

    typedef struct packed {
        logic       deck_attached;
        logic [7:0] command_byte;
        logic       card_present;
        logic       end_of_file_seen;
        logic       card_error;
        logic [7:0] sense_byte;
        logic [6:0] column_index;
    } dev_state_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] cmd;
        logic [1:0] read_outcome;
        logic [7:0] column_code;
        logic       column_invalid;
        logic       channel_stop;
    } item_t;

    typedef struct packed {
        logic [6:0] next_column;
        logic [1:0] wait_code;
        logic [4:0] attn_status;
        logic       attn_valid;
        logic [4:0] end_status;
        logic       end_valid;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [4:0] start_status;
    } result_t;

endpackage

### design/card_reader_channel_control.sv
// Top level of the card reader channel control unit.
//
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tuser: func; s_tdata: cmd, read_outcome,
//         |     |                    |   column_code, column_invalid, channel_stop
// m       | out | m_tvalid/m_tready  | m_tdata: start_status .. next_column
//
// One transaction per cycle: the device state updates in the accept cycle and the result
// lands in a two-entry output buffer, whose head entry drives m.
// The buffer sets the rate: s_tready drops only when both entries are held by a stalled m.
// rst_n clears the device state and empties the buffer; no clearing pass is needed.
module card_reader_channel_control
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] cmd, [9:8] read_outcome, [17:10] column_code, [18] column_invalid,
    // [19] channel_stop, [23:20] zero
    input  logic [crcc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] func
    input  logic [crcc_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] start_status, [5] data_valid, [13:6] data_byte, [14] end_valid,
    // [19:15] end_status, [20] attn_valid, [25:21] attn_status, [27:26] wait_code,
    // [34:28] next_column, [39:35] zero
    output logic [crcc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    crcc_pkg::dev_state_t state_reg;
    crcc_pkg::dev_state_t state_next;
    crcc_pkg::item_t      item;
    crcc_pkg::result_t    step_res;
    crcc_pkg::result_t    out_res;
    logic                 accept;

    assign item.func           = crcc_pkg::func_t'(s_tuser);
    assign item.cmd            = s_tdata[7:0];
    assign item.read_outcome   = s_tdata[9:8];
    assign item.column_code    = s_tdata[17:10];
    assign item.column_invalid = s_tdata[18];
    assign item.channel_stop   = s_tdata[19];

    assign accept = s_tvalid && s_tready;

    crcc_step u_step
    (
        .cur  (state_reg),
        .item (item),
        .nxt  (state_next),
        .res  (step_res)
    );

    crcc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(crcc_pkg::OUT_DATA_W - crcc_pkg::RESULT_W){1'b0}}, out_res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.column_index <= crcc_pkg::COLUMNS_PER_CARD)
        else $error("column index beyond card width");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted transaction left no result");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_data_not_attn: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[5] && m_tdata[20]))
        else $error("data byte and attention in one result");
`endif

endmodule

### design/crcc_step.sv
// Next-state and result logic for one transaction of the card reader control.
module crcc_step
(
    input  crcc_pkg::dev_state_t cur,
    input  crcc_pkg::item_t      item,
    output crcc_pkg::dev_state_t nxt,
    output crcc_pkg::result_t    res
);

    function automatic crcc_pkg::dev_state_t take_card(
        input crcc_pkg::dev_state_t s,
        input logic [1:0]           outcome,
        input logic                 eof_marks
    );
        crcc_pkg::dev_state_t r;
        r = s;
        if (outcome == crcc_pkg::RD_ERROR)
        begin
            r.card_error   = 1'b1;
            r.card_present = 1'b1;
        end
        else if (outcome == crcc_pkg::RD_OK)
        begin
            r.card_present = 1'b1;
        end
        else if (outcome == crcc_pkg::RD_EOF && eof_marks)
        begin
            r.end_of_file_seen = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        crcc_pkg::dev_state_t s;
        crcc_pkg::result_t    r;
        logic [7:0]           op;
        logic [7:0]           ch;
        logic                 finish;
        logic [6:0]           col;

        s      = cur;
        r      = '0;
        op     = cur.command_byte & crcc_pkg::OP_MASK;
        ch     = item.column_code;
        finish = 1'b0;
        col    = cur.column_index;

        case (item.func)
            crcc_pkg::FUNC_START:
            begin
                if (op != 8'h00)
                begin
                    r.start_status = crcc_pkg::ST_BUSY;
                end
                else if (item.cmd != crcc_pkg::CMD_SENSE && !cur.deck_attached)
                begin
                    s.sense_byte   = crcc_pkg::SENSE_INTERV;
                    r.start_status = crcc_pkg::ST_CE | crcc_pkg::ST_DE | crcc_pkg::ST_UC;
                end
                else
                begin
                    case (item.cmd[2:0])
                        crcc_pkg::OPC_READ:
                        begin
                            s.sense_byte   = 8'h00;
                            s.column_index = 7'd0;
                            if (cur.end_of_file_seen)
                            begin
                                s.end_of_file_seen = 1'b0;
                                s.card_error       = 1'b0;
                                s = take_card(s, item.read_outcome, 1'b1);
                                r.start_status = crcc_pkg::ST_CE | crcc_pkg::ST_DE
                                               | crcc_pkg::ST_UE;
                            end
                            else if (!cur.card_present)
                            begin
                                s.sense_byte   = crcc_pkg::SENSE_INTERV;
                                r.start_status = crcc_pkg::ST_CE | crcc_pkg::ST_DE
                                               | crcc_pkg::ST_UC;
                            end
                            else
                            begin
                                s.command_byte = item.cmd;
                                r.wait_code    = crcc_pkg::WAIT_COLUMN;
                            end
                        end
                        crcc_pkg::OPC_CONTROL:
                        begin
                            s.sense_byte   = 8'h00;
                            s.command_byte = 8'h00;
                            if (item.cmd == crcc_pkg::CMD_NOP)
                            begin
                                r.start_status = crcc_pkg::ST_CE | crcc_pkg::ST_DE;
                            end
                            else if ((item.cmd & crcc_pkg::CTL_MASK) != crcc_pkg::CTL_FEED
                                     || (item.cmd & crcc_pkg::STK_MASK) == crcc_pkg::STK_MASK)
                            begin
                                s.sense_byte   = crcc_pkg::SENSE_REJECT;
                                r.start_status = crcc_pkg::ST_CE | crcc_pkg::ST_DE
                                               | crcc_pkg::ST_UC;
                            end
                            else
                            begin
                                s.card_present = 1'b0;
                                s.card_error   = 1'b0;
                                s.command_byte = item.cmd;
                                s.column_index = 7'd0;
                                r.wait_code    = crcc_pkg::WAIT_FEED;
                                r.start_status = crcc_pkg::ST_CE;
                            end
                        end
                        crcc_pkg::OPC_STATUS:
                        begin
                            r.start_status = 5'h00;
                        end
                        crcc_pkg::OPC_SENSE:
                        begin
                            s.command_byte = item.cmd;
                            r.wait_code    = crcc_pkg::WAIT_SHORT;
                        end
                        default:
                        begin
                            s.sense_byte   = cur.sense_byte | crcc_pkg::SENSE_REJECT;
                            r.start_status = crcc_pkg::ST_CE | crcc_pkg::ST_DE
                                           | crcc_pkg::ST_UC;
                        end
                    endcase
                end
            end
            crcc_pkg::FUNC_TICK:
            begin
                if (op == crcc_pkg::OP_SENSE)
                begin
                    r.data_byte = cur.sense_byte;
                    if (cur.sense_byte == 8'h00 && !cur.deck_attached)
                    begin
                        r.data_byte = crcc_pkg::SENSE_INTERV;
                    end
                    r.data_valid   = 1'b1;
                    r.end_valid    = 1'b1;
                    r.end_status   = crcc_pkg::ST_CE | crcc_pkg::ST_DE;
                    s.command_byte = cur.command_byte & ~crcc_pkg::OP_MASK;
                    s.sense_byte   = 8'h00;
                end
                else if (!cur.card_present)
                begin
                    s.end_of_file_seen = 1'b0;
                    s.card_error       = 1'b0;
                    s.command_byte     = cur.command_byte & ~crcc_pkg::OP_MASK;
                    s = take_card(s, item.read_outcome, 1'b1);
                    r.attn_valid  = 1'b1;
                    r.attn_status = crcc_pkg::ST_DE
                                  | (cur.card_error ? crcc_pkg::ST_UC : 5'h00);
                end
                else if (op == crcc_pkg::OP_READ)
                begin
                    if (cur.card_error)
                    begin
                        s.sense_byte = crcc_pkg::SENSE_DATCHK;
                        finish       = 1'b1;
                    end
                    else
                    begin
                        if (item.column_invalid)
                        begin
                            s.sense_byte = cur.sense_byte | crcc_pkg::SENSE_DATCHK;
                            ch           = 8'h00;
                        end
                        if (item.channel_stop)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            r.data_valid = 1'b1;
                            r.data_byte  = ch;
                            if (col < crcc_pkg::COLUMNS_PER_CARD)
                            begin
                                col = col + 7'd1;
                            end
                            s.column_index = col;
                            if (col >= crcc_pkg::COLUMNS_PER_CARD)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                r.wait_code = crcc_pkg::WAIT_COLUMN;
                            end
                        end
                    end
                    if (finish)
                    begin
                        r.end_valid = 1'b1;
                        if ((cur.command_byte & crcc_pkg::STK_MASK) != crcc_pkg::STK_MASK)
                        begin
                            s.card_present = 1'b0;
                            r.end_status   = crcc_pkg::ST_CE;
                            r.wait_code    = crcc_pkg::WAIT_FEED;
                        end
                        else
                        begin
                            r.end_status   = crcc_pkg::ST_CE | crcc_pkg::ST_DE
                                           | (cur.card_error ? crcc_pkg::ST_UC : 5'h00);
                            s.command_byte = 8'h00;
                        end
                    end
                end
            end
            crcc_pkg::FUNC_ATTACH:
            begin
                s.deck_attached = 1'b1;
                if (!cur.card_present)
                begin
                    s.end_of_file_seen = 1'b0;
                    s.card_error       = 1'b0;
                    s.sense_byte       = 8'h00;
                    s.column_index     = 7'd0;
                    s = take_card(s, item.read_outcome, 1'b0);
                    r.attn_valid  = 1'b1;
                    r.attn_status = crcc_pkg::ST_DE;
                end
            end
            crcc_pkg::FUNC_DETACH:
            begin
                s.deck_attached    = 1'b0;
                s.sense_byte       = 8'h00;
                s.card_present     = 1'b0;
                s.end_of_file_seen = 1'b0;
                s.card_error       = 1'b0;
            end
            default:
            begin
                s = cur;
            end
        endcase

        r.next_column = s.column_index;
        nxt = s;
        res = r;
    end

endmodule

### design/crcc_out_buf.sv
// Two-entry output buffer that decouples result delivery from item acceptance.
module crcc_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  crcc_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output crcc_pkg::result_t out_data
);

    logic              head_valid_reg;
    logic              skid_valid_reg;
    crcc_pkg::result_t head_reg;
    crcc_pkg::result_t skid_reg;
    logic              pop;

    assign pop       = head_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= push;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            head_reg <= skid_reg;
            if (push)
            begin
                skid_reg <= push_data;
            end
        end
        else if (push && (pop || !head_valid_reg))
        begin
            head_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

### dv/card_reader_channel_control_test.sv
// Self-checking stream testbench for the card reader channel control unit.
module card_reader_channel_control_test;
    import crcc_pkg::*;

    localparam logic [2:0] UNDEF_OPCODES [4] = '{3'd1, 3'd5, 3'd6, 3'd7};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    item_t       pending_items [$];
    result_t     expected_results [$];
    item_t       offered;
    dev_state_t  reader_state = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned queued_count = 0;
    int unsigned mismatches = 0;
    logic        long_hold_req = 1'b0;
    logic        long_hold = 1'b0;

    card_reader_channel_control dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void load_card(input logic [1:0] outcome, input logic mark_eof);
        if (outcome == RD_ERROR)
        begin
            reader_state.card_error = 1'b1;
            reader_state.card_present = 1'b1;
        end
        else if (outcome == RD_OK)
            reader_state.card_present = 1'b1;
        else if (outcome == RD_EOF && mark_eof)
            reader_state.end_of_file_seen = 1'b1;
    endfunction

    function automatic result_t reader_step(input item_t it);
        result_t    r;
        logic [7:0] op;
        logic [7:0] ch;
        logic       finish;
        r = '0;
        op = reader_state.command_byte & OP_MASK;
        case (it.func)
            FUNC_START:
            begin
                if (op != 8'd0)
                    r.start_status = ST_BUSY;
                else if (it.cmd != CMD_SENSE && !reader_state.deck_attached)
                begin
                    reader_state.sense_byte = SENSE_INTERV;
                    r.start_status = ST_CE | ST_DE | ST_UC;
                end
                else
                begin
                    case (it.cmd[2:0])
                        OPC_READ:
                        begin
                            reader_state.sense_byte = 8'd0;
                            reader_state.column_index = '0;
                            if (reader_state.end_of_file_seen)
                            begin
                                reader_state.end_of_file_seen = 1'b0;
                                reader_state.card_error = 1'b0;
                                load_card(it.read_outcome, 1'b1);
                                r.start_status = ST_CE | ST_DE | ST_UE;
                            end
                            else if (!reader_state.card_present)
                            begin
                                reader_state.sense_byte = SENSE_INTERV;
                                r.start_status = ST_CE | ST_DE | ST_UC;
                            end
                            else
                            begin
                                reader_state.command_byte = it.cmd;
                                r.wait_code = WAIT_COLUMN;
                            end
                        end
                        OPC_CONTROL:
                        begin
                            reader_state.sense_byte = 8'd0;
                            reader_state.command_byte = 8'd0;
                            if (it.cmd == CMD_NOP)
                                r.start_status = ST_CE | ST_DE;
                            else if ((it.cmd & CTL_MASK) != CTL_FEED
                                     || (it.cmd & STK_MASK) == STK_MASK)
                            begin
                                reader_state.sense_byte = SENSE_REJECT;
                                r.start_status = ST_CE | ST_DE | ST_UC;
                            end
                            else
                            begin
                                reader_state.card_present = 1'b0;
                                reader_state.card_error = 1'b0;
                                reader_state.command_byte = it.cmd;
                                reader_state.column_index = '0;
                                r.wait_code = WAIT_FEED;
                                r.start_status = ST_CE;
                            end
                        end
                        OPC_STATUS:
                            r.start_status = '0;
                        OPC_SENSE:
                        begin
                            reader_state.command_byte = it.cmd;
                            r.wait_code = WAIT_SHORT;
                        end
                        default:
                        begin
                            reader_state.sense_byte = reader_state.sense_byte | SENSE_REJECT;
                            r.start_status = ST_CE | ST_DE | ST_UC;
                        end
                    endcase
                end
            end
            FUNC_TICK:
            begin
                if (op == OP_SENSE)
                begin
                    r.data_byte = reader_state.sense_byte;
                    if (r.data_byte == 8'd0 && !reader_state.deck_attached)
                        r.data_byte = SENSE_INTERV;
                    r.data_valid = 1'b1;
                    r.end_valid = 1'b1;
                    r.end_status = ST_CE | ST_DE;
                    reader_state.command_byte = reader_state.command_byte & ~OP_MASK;
                    reader_state.sense_byte = 8'd0;
                end
                else if (!reader_state.card_present)
                begin
                    r.attn_status = ST_DE | (reader_state.card_error ? ST_UC : 5'd0);
                    r.attn_valid = 1'b1;
                    reader_state.end_of_file_seen = 1'b0;
                    reader_state.card_error = 1'b0;
                    reader_state.command_byte = reader_state.command_byte & ~OP_MASK;
                    load_card(it.read_outcome, 1'b1);
                end
                else if (op == OP_READ)
                begin
                    finish = 1'b0;
                    if (reader_state.card_error)
                    begin
                        reader_state.sense_byte = SENSE_DATCHK;
                        finish = 1'b1;
                    end
                    else
                    begin
                        ch = it.column_code;
                        if (it.column_invalid)
                        begin
                            reader_state.sense_byte = reader_state.sense_byte | SENSE_DATCHK;
                            ch = 8'd0;
                        end
                        if (it.channel_stop)
                            finish = 1'b1;
                        else
                        begin
                            r.data_valid = 1'b1;
                            r.data_byte = ch;
                            if (reader_state.column_index < COLUMNS_PER_CARD)
                                reader_state.column_index = reader_state.column_index + 7'd1;
                            if (reader_state.column_index >= COLUMNS_PER_CARD)
                                finish = 1'b1;
                            else
                                r.wait_code = WAIT_COLUMN;
                        end
                    end
                    if (finish)
                    begin
                        r.end_valid = 1'b1;
                        if ((reader_state.command_byte & STK_MASK) != STK_MASK)
                        begin
                            reader_state.card_present = 1'b0;
                            r.end_status = ST_CE;
                            r.wait_code = WAIT_FEED;
                        end
                        else
                        begin
                            r.end_status = ST_CE | ST_DE
                                           | (reader_state.card_error ? ST_UC : 5'd0);
                            reader_state.command_byte = 8'd0;
                        end
                    end
                end
            end
            FUNC_ATTACH:
            begin
                reader_state.deck_attached = 1'b1;
                if (!reader_state.card_present)
                begin
                    reader_state.end_of_file_seen = 1'b0;
                    reader_state.card_error = 1'b0;
                    reader_state.sense_byte = 8'd0;
                    reader_state.column_index = '0;
                    load_card(it.read_outcome, 1'b0);
                    r.attn_valid = 1'b1;
                    r.attn_status = ST_DE;
                end
            end
            default:
            begin
                reader_state.deck_attached = 1'b0;
                reader_state.sense_byte = 8'd0;
                reader_state.card_present = 1'b0;
                reader_state.end_of_file_seen = 1'b0;
                reader_state.card_error = 1'b0;
            end
        endcase
        r.next_column = reader_state.column_index;
        return r;
    endfunction

    // Driver: present queued items, predict each one at acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            reader_state = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(reader_step(offered));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'd0, offered.channel_stop, offered.column_invalid,
                                offered.column_code, offered.read_outcome, offered.cmd};
                    s_tuser <= offered.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing expected: %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.start_status !== want.start_status
                        || got.data_valid !== want.data_valid
                        || got.data_byte !== want.data_byte
                        || got.end_valid !== want.end_valid
                        || got.end_status !== want.end_status
                        || got.attn_valid !== want.attn_valid
                        || got.attn_status !== want.attn_status
                        || got.wait_code !== want.wait_code
                        || got.next_column !== want.next_column)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected st=%h dv=%b db=%h ev=%b es=%h ",
                                      "av=%b as=%h wait=%0d col=%0d"},
                                     want.start_status, want.data_valid, want.data_byte,
                                     want.end_valid, want.end_status, want.attn_valid,
                                     want.attn_status, want.wait_code, want.next_column);
                        if (mismatches <= 10)
                            $display({"          actual   st=%h dv=%b db=%h ev=%b es=%h ",
                                      "av=%b as=%h wait=%0d col=%0d"},
                                     got.start_status, got.data_valid, got.data_byte,
                                     got.end_valid, got.end_status, got.attn_valid,
                                     got.attn_status, got.wait_code, got.next_column);
                    end
                end
            end
            m_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        wait (long_hold_req);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic put_item(input func_t fn, input logic [7:0] cmd, input logic [1:0] outcome,
                            input logic [7:0] code, input logic invalid, input logic stop);
        item_t it;
        it.func = fn;
        it.cmd = cmd;
        it.read_outcome = outcome;
        it.column_code = code;
        it.column_invalid = invalid;
        it.channel_stop = stop;
        pending_items.push_back(it);
        queued_count++;
    endtask

    function automatic logic [1:0] pick_outcome();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6)
            return RD_OK;
        else if (r == 6)
            return RD_ERROR;
        else if (r == 7)
            return RD_EMPTY;
        return RD_EOF;
    endfunction

    task automatic put_tick(input logic stop);
        put_item(FUNC_TICK, 8'($urandom), pick_outcome(), 8'($urandom),
                 $urandom_range(15) == 0, stop);
    endtask

    task automatic add_scenario();
        int unsigned r;
        int unsigned n;
        logic [7:0]  c;
        logic        full;
        r = $urandom_range(99);
        if (r < 55)
        begin
            c = {2'($urandom), 3'b000, OPC_READ};
            if ($urandom_range(7) == 0)
                c = 8'($urandom);
            full = ($urandom_range(19) == 0);
            put_item(FUNC_START, c, pick_outcome(), 8'($urandom), 1'($urandom_range(1)),
                     1'b0);
            n = full ? 82 : $urandom_range(1, 12);
            repeat (n)
                put_tick(!full && $urandom_range(11) == 0);
            put_tick(1'b0);
        end
        else if (r < 68)
        begin
            c = ($urandom_range(3) == 0) ? {5'($urandom), OPC_SENSE} : CMD_SENSE;
            put_item(FUNC_START, c, pick_outcome(), 8'($urandom), 1'($urandom_range(1)),
                     1'b0);
            put_tick(1'($urandom_range(1)));
        end
        else if (r < 78)
        begin
            c = {2'($urandom_range(2)), CTL_FEED[5:4], 1'b0, OPC_CONTROL};
            if ($urandom_range(3) == 0)
                c = {5'($urandom), OPC_CONTROL};
            put_item(FUNC_START, c, pick_outcome(), 8'($urandom), 1'b0,
                     1'($urandom_range(1)));
            put_tick(1'b0);
        end
        else if (r < 86)
        begin
            if ($urandom_range(2) == 0)
                put_item(FUNC_DETACH, 8'($urandom), pick_outcome(), 8'($urandom),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            put_item(FUNC_ATTACH, 8'($urandom), pick_outcome(), 8'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else
            put_item(func_t'($urandom_range(3)), 8'($urandom), 2'($urandom), 8'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count);
        int unsigned target;
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = queued_count + count;
        while (queued_count < target)
            add_scenario();
        drain();
    endtask

    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put_item(FUNC_START, {3'b000, 2'b00, OPC_READ}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, CMD_SENSE, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_EMPTY, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_ATTACH, 8'h00, RD_EOF, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {5'b00000, OPC_READ}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_ATTACH, 8'h00, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_ATTACH, 8'h00, RD_ERROR, 8'h00, 1'b0, 1'b0);
        for (i = 0; i < 4; i++)
            put_item(FUNC_START, {5'b11111, UNDEF_OPCODES[i]}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {5'b11111, OPC_STATUS}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, CMD_NOP, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {2'b00, 2'b01, 1'b0, OPC_CONTROL}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {STK_MASK[7:6], CTL_FEED[5:4], 1'b0, OPC_CONTROL}, RD_OK,
                 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {STK_MASK[7:6], 3'b000, OPC_READ}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {5'b00000, OPC_READ}, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'hFF, RD_EOF, 8'hFF, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_OK, 8'hA5, 1'b1, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_OK, 8'h5A, 1'b0, 1'b1);
        put_item(FUNC_START, CMD_SENSE, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {2'b00, CTL_FEED[5:4], 1'b0, OPC_CONTROL}, RD_OK,
                 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_OK, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_DETACH, 8'hFF, RD_EOF, 8'hFF, 1'b1, 1'b1);
        put_item(FUNC_ATTACH, 8'h00, RD_EOF, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_TICK, 8'h00, RD_EOF, 8'h00, 1'b0, 1'b0);
        put_item(FUNC_START, {5'b00000, OPC_READ}, RD_OK, 8'h00, 1'b0, 1'b0);
        drain();

        run_phase(0, 0, 200);
        run_phase(50, 0, 200);
        run_phase(0, 50, 200);
        run_phase(22, 22, 200);

        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_req = 1'b1;
        repeat (20)
            add_scenario();
        drain();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
design/crcc_pkg.sv
design/crcc_step.sv
design/crcc_out_buf.sv
design/card_reader_channel_control.sv
dv/card_reader_channel_control_test.sv
